// File: rtl/core/mtt_pkg.sv
// ============================================================================
// mtt_pkg
// Shared types and constants of the multi timer table.
// ============================================================================
package mtt_pkg;

    localparam int SLOTS   = 16;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int CFG_IDX_W = 1;

    localparam logic [15:0] CAP_RESET  = 16'd5;
    localparam logic [15:0] BASE_RESET = 16'd1024;

    localparam logic [CFG_IDX_W-1:0] REG_ALARM_CAP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ID_BASE   = 1'b1;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_RESET  = 2'd2;
    localparam logic [1:0] MODE_TICK   = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_IVL  = 3'd1;
    localparam logic [2:0] ST_IN_USE   = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] timer_id;
        logic        no_id;
        logic [7:0]  owner;
        logic        any_owner;
        logic [15:0] interval_seconds;
        logic        auto_restart;
        logic [15:0] elapsed_seconds;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] event_id;
        logic [7:0]  event_owner;
        logic [16:0] run_seconds;
        logic [2:0]  status;
        logic [15:0] id_or_count;
        logic [15:0] next_alarm;
        logic        last;
    } out_item_t;

    // compare unit request/response
    typedef struct packed {
        logic [15:0] a_rem;
        logic [SLOT_W-1:0] a_idx;
        logic        a_ok;
        logic [15:0] b_rem;
        logic [SLOT_W-1:0] b_idx;
        logic        b_ok;
    } cmp_req_t;

    typedef struct packed {
        logic        take_a;
    } cmp_rsp_t;

endpackage

// File: rtl/core/mtt_order_cmp.sv
// ============================================================================
// mtt_order_cmp
// Shared table-order compare: is candidate a ahead of best b.
// ============================================================================
module mtt_order_cmp (
    input  mtt_pkg::cmp_req_t req,
    output mtt_pkg::cmp_rsp_t rsp
);
    always_comb
    begin
        if (!req.a_ok)
            rsp.take_a = 1'b0;
        else if (!req.b_ok)
            rsp.take_a = 1'b1;
        else if (req.a_rem != req.b_rem)
            rsp.take_a = req.a_rem < req.b_rem;
        else
            rsp.take_a = req.a_idx < req.b_idx;
    end
endmodule

// File: rtl/core/multi_timer_table_unit.sv
// ============================================================================
// multi_timer_table_unit
// Table of software timers with add, remove, reset and tick operations.
// ============================================================================
// Usage:
//   in channel (in_valid/in_stall/in_data) takes one operation item.
//   out channel (out_valid/out_stall/out_data) returns result items:
//   for a tick, one expiry event per expired timer in ascending remaining
//   order (ties to lower slot), then always one status item with last=1.
//   Config writes (cfg_we/cfg_index/cfg_data) set alarm_cap and the dynamic
//   id base; write only while idle.
// Sequence:
//   A scan walks the slots one per cycle through a single shared order
//   compare, but waits at the last slot while the output register is held.
//   Add/remove/reset: match scan, commit step, alarm scan; the status item
//   is loaded at the end of the alarm scan. Tick with E events: E+1 event
//   passes, one update pass and the alarm pass. in_stall stays high while
//   an item is in work and drops in the cycle after the status is loaded.
// Reset: all slots free, cap 5, id base 1024; no clearing pass needed.
// Stall: each result waits in the output register; the scan stops until
//   it is taken, so nothing is lost.
// ============================================================================
module multi_timer_table_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mtt_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output mtt_pkg::out_item_t  out_data,
    input  logic                cfg_we,
    input  logic [mtt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]         cfg_data
);
    localparam int SW = mtt_pkg::SLOT_W;
    localparam int CW = mtt_pkg::CNT_W;
    localparam int SLOTS_M1 = mtt_pkg::SLOTS - 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,  // matching/free scan for add, remove, reset
        S_APPLY = 6'b000100,  // commit the operation
        S_EVT   = 6'b001000,  // tick: find next expired slot
        S_UPD   = 6'b010000,  // tick: update slot by slot
        S_ALARM = 6'b100000   // least remaining scan, then status
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] cap_reg, base_reg, dyn_reg;
    mtt_pkg::in_item_t op_reg;

    logic [SLOTS_M1:0] valid_reg;
    logic [15:0] id_mem  [mtt_pkg::SLOTS];
    logic [7:0]  own_mem [mtt_pkg::SLOTS];
    logic [15:0] ivl_mem [mtt_pkg::SLOTS];
    logic [15:0] rem_mem [mtt_pkg::SLOTS];
    logic        rst_mem [mtt_pkg::SLOTS];
    logic [SLOTS_M1:0] done_reg;  // expiries already emitted

    logic [SW-1:0] idx_reg;
    logic          idx_last;
    logic          best_ok_reg, free_ok_reg, dup_reg;
    logic [SW-1:0] best_idx_reg, free_idx_reg;
    logic [15:0]   best_rem_reg;
    logic [CW-1:0] cnt_reg;
    logic [2:0]    st_reg;    // status of the item in work
    logic [15:0]   ioc_reg;   // id or count of the item in work

    logic out_valid_reg;
    logic out_load;
    mtt_pkg::out_item_t out_reg;

    assign idx_last = (idx_reg == SW'(SLOTS_M1));
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    wire out_free = !out_valid_reg || !out_stall;

    // current slot fields
    wire        cv   = valid_reg[idx_reg];
    wire [15:0] crem = rem_mem[idx_reg];
    wire        id_hit  = id_mem[idx_reg] == op_reg.timer_id;
    wire        own_hit = op_reg.any_owner || own_mem[idx_reg] == op_reg.owner;
    wire        expd = cv && op_reg.elapsed_seconds != 16'd0 &&
                       op_reg.elapsed_seconds >= crem;

    logic cand;
    always_comb
    begin
        case (state_reg)
            S_SCAN:  cand = cv && id_hit && own_hit;
            S_EVT:   cand = expd && !done_reg[idx_reg];
            S_ALARM: cand = cv;
            default: cand = 1'b0;
        endcase
    end

    mtt_pkg::cmp_req_t creq;
    mtt_pkg::cmp_rsp_t crsp;
    assign creq = '{a_rem: crem, a_idx: idx_reg, a_ok: cand,
                    b_rem: best_rem_reg, b_idx: best_idx_reg, b_ok: best_ok_reg};
    mtt_order_cmp u_cmp (.req(creq), .rsp(crsp));

    logic [15:0] dyn_id;
    assign dyn_id = (dyn_reg < base_reg) ? base_reg : dyn_reg;

    // a result item enters the output register: an event at the end of a
    // pass with a winner, or the status at the end of the alarm scan
    assign out_load = out_free && idx_last &&
                      ((state_reg == S_EVT && (best_ok_reg || crsp.take_a)) ||
                       state_reg == S_ALARM);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = (in_data.mode == mtt_pkg::MODE_TICK) ? S_EVT : S_SCAN;
            S_SCAN:
                if (idx_last) state_next = S_APPLY;
            S_APPLY:
                if (out_free) state_next = S_ALARM;
            S_EVT:
                if (idx_last && (!best_ok_reg && !crsp.take_a)) state_next = S_UPD;
            S_UPD:
                if (idx_last) state_next = S_ALARM;
            S_ALARM:
                if (idx_last && out_free) state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // slot stores: payload only, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == S_APPLY && out_free && op_reg.mode == mtt_pkg::MODE_ADD &&
            op_reg.interval_seconds != 16'd0 && !dup_reg && free_ok_reg)
        begin
            id_mem[free_idx_reg]  <= op_reg.no_id ? dyn_id : op_reg.timer_id;
            own_mem[free_idx_reg] <= op_reg.owner;
            ivl_mem[free_idx_reg] <= op_reg.interval_seconds;
            rem_mem[free_idx_reg] <= op_reg.interval_seconds;
            rst_mem[free_idx_reg] <= op_reg.auto_restart;
        end
        else if (state_reg == S_APPLY && out_free && op_reg.mode == mtt_pkg::MODE_RESET &&
                 best_ok_reg)
            rem_mem[best_idx_reg] <= ivl_mem[best_idx_reg];
        else if (state_reg == S_UPD && cv)
        begin
            if (expd)
                rem_mem[idx_reg] <= ivl_mem[idx_reg];
            else
                rem_mem[idx_reg] <= crem - op_reg.elapsed_seconds;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            op_reg <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= mtt_pkg::CAP_RESET;
            base_reg      <= mtt_pkg::BASE_RESET;
            dyn_reg       <= mtt_pkg::BASE_RESET;
            valid_reg     <= '0;
            done_reg      <= '0;
            idx_reg       <= '0;
            best_ok_reg   <= 1'b0;
            best_idx_reg  <= '0;
            best_rem_reg  <= '0;
            free_ok_reg   <= 1'b0;
            free_idx_reg  <= '0;
            dup_reg       <= 1'b0;
            cnt_reg       <= '0;
            st_reg        <= mtt_pkg::ST_OK;
            ioc_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_index)
                    mtt_pkg::REG_ALARM_CAP: cap_reg <= cfg_data;
                    mtt_pkg::REG_ID_BASE:   base_reg <= cfg_data;
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    idx_reg     <= '0;
                    best_ok_reg <= 1'b0;
                    free_ok_reg <= 1'b0;
                    dup_reg     <= 1'b0;
                    cnt_reg     <= '0;
                    done_reg    <= '0;
                    st_reg      <= mtt_pkg::ST_OK;
                    ioc_reg     <= '0;
                end
                S_SCAN:
                begin
                    if (crsp.take_a)
                    begin
                        best_ok_reg  <= 1'b1;
                        best_idx_reg <= idx_reg;
                        best_rem_reg <= crem;
                    end
                    if (!cv && !free_ok_reg)
                    begin
                        free_ok_reg  <= 1'b1;
                        free_idx_reg <= idx_reg;
                    end
                    if (cv && id_hit && !op_reg.no_id)
                        dup_reg <= 1'b1;
                    // remove all: drop matches on the fly
                    if (op_reg.mode == mtt_pkg::MODE_REMOVE && op_reg.no_id && cv && own_hit)
                    begin
                        valid_reg[idx_reg] <= 1'b0;
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    idx_reg <= idx_last ? '0 : idx_reg + SW'(1);
                end
                S_APPLY:
                    if (out_free)
                    begin
                        best_ok_reg <= 1'b0;
                        idx_reg     <= '0;
                        case (op_reg.mode)
                            mtt_pkg::MODE_ADD:
                                if (op_reg.interval_seconds == 16'd0)
                                    st_reg <= mtt_pkg::ST_BAD_IVL;
                                else if (dup_reg)
                                    st_reg <= mtt_pkg::ST_IN_USE;
                                else if (!free_ok_reg)
                                    st_reg <= mtt_pkg::ST_FULL;
                                else
                                begin
                                    valid_reg[free_idx_reg] <= 1'b1;
                                    if (op_reg.no_id)
                                    begin
                                        ioc_reg <= dyn_id;
                                        dyn_reg <= dyn_id + 16'd1;
                                    end
                                    else
                                        ioc_reg <= op_reg.timer_id;
                                end
                            mtt_pkg::MODE_REMOVE:
                                if (op_reg.no_id)
                                begin
                                    if (cnt_reg == '0)
                                        st_reg <= mtt_pkg::ST_NOTFOUND;
                                    else
                                        ioc_reg <= 16'(cnt_reg);
                                end
                                else if (!best_ok_reg)
                                    st_reg <= mtt_pkg::ST_NOTFOUND;
                                else
                                begin
                                    valid_reg[best_idx_reg] <= 1'b0;
                                    ioc_reg <= op_reg.timer_id;
                                end
                            default:
                                if (!best_ok_reg)
                                    st_reg <= mtt_pkg::ST_NOTFOUND;
                                else
                                    ioc_reg <= id_mem[best_idx_reg];
                        endcase
                    end
                S_EVT:
                begin
                    if (idx_last)
                    begin
                        // end of a pass: emit winner, or move on
                        if (best_ok_reg || crsp.take_a)
                        begin
                            if (out_free)
                            begin
                                logic [SW-1:0] w;
                                w = crsp.take_a ? idx_reg : best_idx_reg;
                                done_reg[w] <= 1'b1;
                                out_reg <= '{kind: 1'b0,
                                             event_id: id_mem[w],
                                             event_owner: own_mem[w],
                                             run_seconds: 17'(ivl_mem[w]) +
                                                 17'(op_reg.elapsed_seconds) -
                                                 17'(rem_mem[w]),
                                             status: mtt_pkg::ST_OK,
                                             id_or_count: 16'd0,
                                             next_alarm: 16'd0,
                                             last: 1'b0};
                                best_ok_reg <= 1'b0;
                                idx_reg     <= '0;
                            end
                        end
                        else
                            idx_reg <= '0;
                    end
                    else
                    begin
                        if (crsp.take_a)
                        begin
                            best_ok_reg  <= 1'b1;
                            best_idx_reg <= idx_reg;
                            best_rem_reg <= crem;
                        end
                        idx_reg <= idx_reg + SW'(1);
                    end
                end
                S_UPD:
                begin
                    if (cv && expd && !rst_mem[idx_reg])
                        valid_reg[idx_reg] <= 1'b0;
                    idx_reg <= idx_last ? '0 : idx_reg + SW'(1);
                    best_ok_reg <= 1'b0;
                end
                S_ALARM:
                begin
                    if (!idx_last)
                    begin
                        if (crsp.take_a)
                        begin
                            best_ok_reg  <= 1'b1;
                            best_idx_reg <= idx_reg;
                            best_rem_reg <= crem;
                        end
                        idx_reg <= idx_reg + SW'(1);
                    end
                    else if (out_free)
                    begin
                        logic [15:0] r;
                        logic        ok;
                        logic [15:0] na;
                        ok = best_ok_reg || crsp.take_a;
                        r  = crsp.take_a ? crem : best_rem_reg;
                        if (!ok)
                            na = 16'd0;
                        else
                            na = (r < cap_reg) ? r : cap_reg;
                        out_reg <= '{kind: 1'b1,
                                     event_id: 16'd0,
                                     event_owner: 8'd0,
                                     run_seconds: 17'd0,
                                     status: st_reg,
                                     id_or_count: ioc_reg,
                                     next_alarm: na,
                                     last: 1'b1};
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTH
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");
    a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.last) |-> out_data.kind)
        else $error("last on an event item");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALARM && idx_last && out_free) |=> (state_reg == S_IDLE))
        else $error("status not closing item");
`endif
endmodule

// File: bench/mtt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mtt_checker
// Watches both channels of the timer table, keeps its own copy of the table
// and compares every result item against the predicted one.
// ----------------------------------------------------------------------------
module mtt_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  mtt_pkg::in_item_t   in_data,
    input  logic       out_valid,
    input  logic       out_stall,
    input  mtt_pkg::out_item_t  out_data,
    input  logic       cfg_we,
    input  logic [mtt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data,
    output int         fail_count,
    output int         pending,
    output int         results_seen
);

    logic        tv_valid [mtt_pkg::SLOTS];
    logic [15:0] tv_id [mtt_pkg::SLOTS];
    logic [7:0]  tv_owner [mtt_pkg::SLOTS];
    logic [15:0] tv_ivl [mtt_pkg::SLOTS];
    logic [15:0] tv_rem [mtt_pkg::SLOTS];
    logic        tv_restart [mtt_pkg::SLOTS];
    logic [15:0] next_dyn;
    logic [15:0] cap;
    logic [15:0] id_base;

    mtt_pkg::out_item_t expected_items[$];

    assign pending = expected_items.size();

    function automatic bit ahead(int a, int b);
        if (tv_rem[a] != tv_rem[b])
            return tv_rem[a] < tv_rem[b];
        return a < b;
    endfunction

    function automatic int first_hit(logic [15:0] id, logic [7:0] own, logic any_own);
        int best;
        best = -1;
        for (int s = 0; s < mtt_pkg::SLOTS; s++)
            if (tv_valid[s] && tv_id[s] == id && (any_own || tv_owner[s] == own)
                && (best < 0 || ahead(s, best)))
                best = s;
        return best;
    endfunction

    function automatic logic [15:0] alarm_now();
        bit          any;
        logic [15:0] least;
        any = 0;
        least = 0;
        for (int s = 0; s < mtt_pkg::SLOTS; s++)
            if (tv_valid[s] && (!any || tv_rem[s] < least))
            begin
                least = tv_rem[s];
                any = 1;
            end
        if (!any)
            return 0;
        return (least < cap) ? least : cap;
    endfunction

    task automatic apply_op(mtt_pkg::in_item_t it);
        mtt_pkg::out_item_t r;
        logic [2:0]  st;
        logic [15:0] ioc;
        int          free_s;
        bit          dup;
        int          m;
        int          n;
        bit          fires [mtt_pkg::SLOTS];
        logic [15:0] id;
        st = mtt_pkg::ST_OK;
        ioc = 0;
        case (it.mode)
            mtt_pkg::MODE_ADD:
            begin
                free_s = -1;
                dup = 0;
                for (int s = 0; s < mtt_pkg::SLOTS; s++)
                    if (!tv_valid[s])
                    begin
                        if (free_s < 0)
                            free_s = s;
                    end
                    else if (!it.no_id && tv_id[s] == it.timer_id)
                        dup = 1;
                if (it.interval_seconds == 0)
                    st = mtt_pkg::ST_BAD_IVL;
                else if (dup)
                    st = mtt_pkg::ST_IN_USE;
                else if (free_s < 0)
                    st = mtt_pkg::ST_FULL;
                else
                begin
                    id = it.timer_id;
                    if (it.no_id)
                    begin
                        if (next_dyn < id_base)
                            next_dyn = id_base;
                        id = next_dyn;
                        next_dyn = next_dyn + 16'd1;
                    end
                    tv_valid[free_s] = 1;
                    tv_id[free_s] = id;
                    tv_owner[free_s] = it.owner;
                    tv_ivl[free_s] = it.interval_seconds;
                    tv_rem[free_s] = it.interval_seconds;
                    tv_restart[free_s] = it.auto_restart;
                    ioc = id;
                end
            end
            mtt_pkg::MODE_REMOVE:
            begin
                if (it.no_id)
                begin
                    n = 0;
                    for (int s = 0; s < mtt_pkg::SLOTS; s++)
                        if (tv_valid[s] && (it.any_owner || tv_owner[s] == it.owner))
                        begin
                            tv_valid[s] = 0;
                            n++;
                        end
                    if (n == 0)
                        st = mtt_pkg::ST_NOTFOUND;
                    else
                        ioc = n[15:0];
                end
                else
                begin
                    m = first_hit(it.timer_id, it.owner, it.any_owner);
                    if (m < 0)
                        st = mtt_pkg::ST_NOTFOUND;
                    else
                    begin
                        tv_valid[m] = 0;
                        ioc = it.timer_id;
                    end
                end
            end
            mtt_pkg::MODE_RESET:
            begin
                m = first_hit(it.timer_id, it.owner, it.any_owner);
                if (m < 0)
                    st = mtt_pkg::ST_NOTFOUND;
                else
                begin
                    tv_rem[m] = tv_ivl[m];
                    ioc = tv_id[m];
                end
            end
            default:
            begin
                for (int s = 0; s < mtt_pkg::SLOTS; s++)
                    fires[s] = tv_valid[s] && it.elapsed_seconds != 0
                               && it.elapsed_seconds >= tv_rem[s];
                // events come out in table order, judged before any reload
                forever
                begin
                    m = -1;
                    for (int s = 0; s < mtt_pkg::SLOTS; s++)
                        if (fires[s] && (m < 0 || ahead(s, m)))
                            m = s;
                    if (m < 0)
                        break;
                    fires[m] = 0;
                    r = '0;
                    r.event_id = tv_id[m];
                    r.event_owner = tv_owner[m];
                    r.run_seconds = {1'b0, tv_ivl[m]} + {1'b0, it.elapsed_seconds}
                                    - {1'b0, tv_rem[m]};
                    expected_items.push_back(r);
                end
                for (int s = 0; s < mtt_pkg::SLOTS; s++)
                    if (tv_valid[s])
                    begin
                        if (it.elapsed_seconds != 0 && it.elapsed_seconds >= tv_rem[s])
                        begin
                            if (tv_restart[s])
                                tv_rem[s] = tv_ivl[s];
                            else
                                tv_valid[s] = 0;
                        end
                        else
                            tv_rem[s] = tv_rem[s] - it.elapsed_seconds;
                    end
            end
        endcase
        r = '0;
        r.kind = 1'b1;
        r.status = st;
        r.id_or_count = ioc;
        r.next_alarm = alarm_now();
        r.last = 1'b1;
        expected_items.push_back(r);
    endtask

    task automatic compare_item(mtt_pkg::out_item_t got);
        mtt_pkg::out_item_t w;
        if (expected_items.size() == 0)
        begin
            $error("result item with nothing expected: %h", got);
            fail_count++;
            return;
        end
        w = expected_items.pop_front();
        if (got.kind != w.kind)
        begin
            $error("kind: expected %0d got %0d", w.kind, got.kind);
            fail_count++;
        end
        if (got.event_id != w.event_id)
        begin
            $error("event_id: expected %0d got %0d", w.event_id, got.event_id);
            fail_count++;
        end
        if (got.event_owner != w.event_owner)
        begin
            $error("event_owner: expected %0d got %0d", w.event_owner, got.event_owner);
            fail_count++;
        end
        if (got.run_seconds != w.run_seconds)
        begin
            $error("run_seconds: expected %0d got %0d", w.run_seconds, got.run_seconds);
            fail_count++;
        end
        if (got.status != w.status)
        begin
            $error("status: expected %0d got %0d", w.status, got.status);
            fail_count++;
        end
        if (got.id_or_count != w.id_or_count)
        begin
            $error("id_or_count: expected %0d got %0d", w.id_or_count, got.id_or_count);
            fail_count++;
        end
        if (got.next_alarm != w.next_alarm)
        begin
            $error("next_alarm: expected %0d got %0d", w.next_alarm, got.next_alarm);
            fail_count++;
        end
        if (got.last != w.last)
        begin
            $error("last: expected %0d got %0d", w.last, got.last);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        results_seen = 0;
        cap = mtt_pkg::CAP_RESET;
        id_base = mtt_pkg::BASE_RESET;
        next_dyn = mtt_pkg::BASE_RESET;
        for (int s = 0; s < mtt_pkg::SLOTS; s++)
            tv_valid[s] = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == mtt_pkg::REG_ALARM_CAP)
                    cap = cfg_data;
                else
                    id_base = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                compare_item(out_data);
                results_seen++;
            end
            if (in_valid && !in_stall)
                apply_op(in_data);
        end
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the multi timer table: directed operations, then random
// add/remove/reset/tick traffic over several register settings.
// ----------------------------------------------------------------------------
module tb;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    mtt_pkg::in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    mtt_pkg::out_item_t out_data;
    logic      cfg_we;
    logic [mtt_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [15:0] cfg_data;

    int  fail_count;
    int  pending;
    int  results_seen;
    int  cycle_count;
    bit  quiet;       // no idling in the closing part
    int  items_sent;

    // worst item: 16 events and 19 scans, with receiver stalls on each result
    localparam int CYCLE_LIMIT = 900000;
    localparam int IN_W = $bits(mtt_pkg::in_item_t);

    multi_timer_table_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mtt_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // receiver stall in bursts
    initial
    begin
        int n;
        out_stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 11);
                out_stall <= 1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 0;
        end
    end

    // one item through the handshake; called at a falling edge, returns at
    // the falling edge after acceptance with valid still up
    task automatic send_op(mtt_pkg::in_item_t it);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_valid <= 1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    function automatic mtt_pkg::in_item_t make_op(logic [1:0] md, logic [15:0] id,
                                                  logic nid, logic [7:0] own,
                                                  logic anyo, logic [15:0] ivl,
                                                  logic rs, logic [15:0] el);
        mtt_pkg::in_item_t it;
        it.mode = md;
        it.timer_id = id;
        it.no_id = nid;
        it.owner = own;
        it.any_owner = anyo;
        it.interval_seconds = ivl;
        it.auto_restart = rs;
        it.elapsed_seconds = el;
        return it;
    endfunction

    task automatic write_reg(logic [mtt_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        // wait until all results are in, then settle
        in_valid <= 0;
        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    // random traffic: mostly small ids/owners so ops hit existing timers
    task automatic random_op();
        mtt_pkg::in_item_t it;
        it = mtt_pkg::in_item_t'(IN_W'({$urandom, $urandom}));
        it.timer_id = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
        it.owner = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: it.mode = mtt_pkg::MODE_ADD;
            4, 5:       it.mode = mtt_pkg::MODE_REMOVE;
            6:          it.mode = mtt_pkg::MODE_RESET;
            default:    it.mode = mtt_pkg::MODE_TICK;
        endcase
        if ($urandom_range(0, 5) != 0)
        begin
            it.interval_seconds = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(0, 40));
            it.elapsed_seconds = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(0, 25));
        end
        send_op(it);
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_we = 0;
        cfg_index = mtt_pkg::REG_ALARM_CAP;
        cfg_data = '0;
        quiet = 0;
        items_sent = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: bad interval, dup, dynamic ids, full table, remove/reset, ticks
        send_op(make_op(mtt_pkg::MODE_ADD, 16'd7, 1'b0, 8'd1, 1'b0, 16'd0, 1'b0, 16'd0));
        send_op(make_op(mtt_pkg::MODE_ADD, 16'd7, 1'b0, 8'd1, 1'b0, 16'd10, 1'b1, 16'd0));
        send_op(make_op(mtt_pkg::MODE_ADD, 16'd7, 1'b0, 8'd2, 1'b0, 16'd3, 1'b0, 16'd0));
        send_op(make_op(mtt_pkg::MODE_ADD, 16'hFFFF, 1'b0, 8'hFF, 1'b0, 16'hFFFF, 1'b0,
                        16'd0));
        for (int i = 0; i < 14; i++)
            send_op(make_op(mtt_pkg::MODE_ADD, 16'd0, 1'b1, 8'(i % 3), 1'b0,
                            16'(2 + i % 4), i[0], 16'd0));
        send_op(make_op(mtt_pkg::MODE_ADD, 16'd99, 1'b0, 8'd1, 1'b0, 16'd5, 1'b0, 16'd0));
        send_op(make_op(mtt_pkg::MODE_TICK, 16'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0, 16'd0));
        send_op(make_op(mtt_pkg::MODE_TICK, 16'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0, 16'd3));
        send_op(make_op(mtt_pkg::MODE_RESET, 16'd7, 1'b0, 8'd9, 1'b1, 16'd0, 1'b0, 16'd0));
        send_op(make_op(mtt_pkg::MODE_RESET, 16'd500, 1'b1, 8'd1, 1'b0, 16'd0, 1'b0,
                        16'd0));
        send_op(make_op(mtt_pkg::MODE_REMOVE, 16'd7, 1'b0, 8'd9, 1'b0, 16'd0, 1'b0,
                        16'd0));
        send_op(make_op(mtt_pkg::MODE_REMOVE, 16'hFFFF, 1'b0, 8'hFF, 1'b0, 16'd0, 1'b0,
                        16'd0));
        send_op(make_op(mtt_pkg::MODE_REMOVE, 16'd0, 1'b1, 8'd1, 1'b0, 16'd0, 1'b0,
                        16'd0));
        send_op(make_op(mtt_pkg::MODE_TICK, 16'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0,
                        16'hFFFF));
        send_op(make_op(mtt_pkg::MODE_REMOVE, 16'd0, 1'b1, 8'd0, 1'b1, 16'd0, 1'b0,
                        16'd0));

        // register extremes, including dynamic id wrap and a zero cap
        write_reg(mtt_pkg::REG_ALARM_CAP, 16'hFFFF);
        write_reg(mtt_pkg::REG_ID_BASE, 16'hFFFE);
        for (int i = 0; i < 33; i++)
            random_op();
        write_reg(mtt_pkg::REG_ALARM_CAP, 16'd1);
        write_reg(mtt_pkg::REG_ID_BASE, 16'd0);
        for (int i = 0; i < 33; i++)
            random_op();
        write_reg(mtt_pkg::REG_ALARM_CAP, 16'd0);
        write_reg(mtt_pkg::REG_ID_BASE, 16'($urandom));
        for (int i = 0; i < 33; i++)
            random_op();
        write_reg(mtt_pkg::REG_ALARM_CAP, 16'd12);
        quiet = 1;
        for (int i = 0; i < 33; i++)
            random_op();
        in_valid <= 0;

        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        $display("sent %0d operation items, checked %0d result items", items_sent,
                 results_seen);
        $display("covered add/remove/reset/tick, dynamic ids, full table, cap extremes");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
